[design/mwfs_pkg.sv]
// ----------------------------------------------------------------------------
// mwfs_pkg - shared types and constants of the magic-word frame synchroniser
// Event codes, controller states, command/status bundles and defaults.
// ----------------------------------------------------------------------------
package mwfs_pkg;

  localparam int HEADER_BYTES_DEF   = 40;
  localparam int CAPACITY_BYTES_DEF = 16384;
  localparam int MAGIC_LEN          = 8;
  localparam int LEN_OFFSET         = 12;
  localparam int DROP_W             = $clog2(MAGIC_LEN);

  localparam logic [63:0] MAGIC_RESET = 64'h0708_0506_0304_0102;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam logic [PADDR_W-4:0] REG_MAGIC = '0;

  // Result event codes
  localparam logic [1:0] EV_FRAME      = 2'd0;
  localparam logic [1:0] EV_UNDERSIZED = 2'd1;
  localparam logic [1:0] EV_OVERSIZED  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LENCHK,
    ST_DROP,
    ST_BURST
  } mwfs_state_t;

  typedef struct packed {
    logic       in_ready;    // take a received byte
    logic       shift;       // advance the window by one byte
    logic       load_event;  // put an event result in the output register
    logic [1:0] event_kind;
    logic       set_frame;   // latch the body length of a committed frame
    logic       load_burst;  // put the front window byte out as a header byte
    logic       drop_load;   // arm the magic-word drop counter
    logic       drop_dec;
  } mwfs_cmd_t;

  typedef struct packed {
    logic rx_valid;
    logic in_frame;
    logic fill_to_full;  // the next appended byte fills the window
    logic fill_full;
    logic fill_low;      // one more shift leaves too few bytes for a magic word
    logic fill_one;
    logic match0;        // magic word sits at the window front
    logic len_under;
    logic len_over;
    logic slot_free;     // output register free or being emptied
    logic drop_done;
  } mwfs_status_t;

endpackage

[design/mwfs_rx_if.sv]
// ----------------------------------------------------------------------------
// mwfs_rx_if - received byte channel
// One byte per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwfs_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/mwfs_frame_if.sv]
// ----------------------------------------------------------------------------
// mwfs_frame_if - frame result channel
// Frame bytes and events, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mwfs_frame_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] frame_byte;
  logic       frame_first;
  logic       frame_last;

  modport source (output valid, output event_kind, output frame_byte,
                  output frame_first, output frame_last, input ready);
  modport sink   (input valid, input event_kind, input frame_byte,
                  input frame_first, input frame_last, output ready);
endinterface

[design/magic_word_frame_sync_top.sv]
// ----------------------------------------------------------------------------
// magic_word_frame_sync_top - magic-word frame synchroniser
// Aligns a received byte stream to framed packets and passes frames through.
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on rx_stream. Outside a frame each byte is
// appended to a header window. When the window fills, the block scans it
// one byte per cycle: it checks for the magic word at the window front and,
// if absent, advances the window by one byte; no new byte is taken
// meanwhile. With the magic word at the front, the length at offset 12 is
// decoded. A short length yields an undersized event and drops one byte; a
// length beyond CAPACITY_BYTES yields an oversized event and drops the magic
// word. A valid length sends the header as HEADER_BYTES output transfers,
// one per cycle while frame_stream is ready. Body bytes then pass through at
// one per cycle while frame_stream is ready, via a single output register.
// The rate is set by the one-byte-per-cycle window shift line and that one
// output register.
// ----------------------------------------------------------------------------
module magic_word_frame_sync_top #(
  parameter int HEADER_BYTES   = mwfs_pkg::HEADER_BYTES_DEF,
  parameter int CAPACITY_BYTES = mwfs_pkg::CAPACITY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // received bytes
  mwfs_rx_if.sink                       rx_stream,
  // frame bytes and events
  mwfs_frame_if.source                  frame_stream,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [mwfs_pkg::PDATA_W-1:0]  pwdata,
  output logic [mwfs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import mwfs_pkg::*;

  logic [63:0]  magic_word;
  mwfs_cmd_t    cmd;
  mwfs_status_t status;

  // magic word register
  mwfs_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .magic_word (magic_word)
  );

  // sequencing: scan, length check, drop, header burst
  mwfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // window, compare, length decode and output register
  mwfs_dp #(
    .HEADER_BYTES   (HEADER_BYTES),
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .magic_word (magic_word),
    .cmd        (cmd),
    .status     (status),
    .rx         (rx_stream),
    .res        (frame_stream)
  );

endmodule

[design/mwfs_regs.sv]
// ----------------------------------------------------------------------------
// mwfs_regs - configuration register file
// Holds the magic word, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module mwfs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [mwfs_pkg::PDATA_W-1:0]  pwdata,
  output logic [mwfs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [63:0]                   magic_word
);
  import mwfs_pkg::*;

  logic                 wr_en;
  logic [PADDR_W-4:0]   reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1:3];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= MAGIC_RESET;
    end else if (wr_en && reg_index == REG_MAGIC) begin
      magic_word <= pwdata;
    end
  end

  // unmapped registers read as zero
  always_comb begin
    prdata = '0;
    if (reg_index == REG_MAGIC) begin
      prdata = magic_word;
    end
  end

endmodule

[design/mwfs_ctrl.sv]
// ----------------------------------------------------------------------------
// mwfs_ctrl - sequencing state machine
// Drives window scan, length check, drop and header burst.
// ----------------------------------------------------------------------------
module mwfs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  mwfs_pkg::mwfs_status_t status,
  output mwfs_pkg::mwfs_cmd_t    cmd
);
  import mwfs_pkg::*;

  mwfs_state_t state;
  mwfs_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.rx_valid && cmd.in_ready && !status.in_frame && status.fill_to_full) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.match0) begin
          state_next = status.fill_full ? ST_LENCHK : ST_IDLE;
        end else if (status.fill_low) begin
          state_next = ST_IDLE;
        end
      end
      ST_LENCHK: begin
        if (status.len_under) begin
          if (status.slot_free) begin
            state_next = ST_IDLE;
          end
        end else if (status.len_over) begin
          if (status.slot_free) begin
            state_next = ST_DROP;
          end
        end else begin
          state_next = ST_BURST;
        end
      end
      ST_DROP: begin
        if (status.drop_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_BURST: begin
        if (status.slot_free && status.fill_one) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.event_kind = EV_FRAME;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = !status.in_frame || status.slot_free;
      end
      ST_SCAN: begin
        cmd.shift = !status.match0;
      end
      ST_LENCHK: begin
        if (status.len_under) begin
          cmd.load_event = status.slot_free;
          cmd.event_kind = EV_UNDERSIZED;
          cmd.shift      = status.slot_free;
        end else if (status.len_over) begin
          cmd.load_event = status.slot_free;
          cmd.event_kind = EV_OVERSIZED;
          cmd.shift      = status.slot_free;
          cmd.drop_load  = status.slot_free;
        end else begin
          cmd.set_frame = 1'b1;
        end
      end
      ST_DROP: begin
        cmd.shift    = 1'b1;
        cmd.drop_dec = 1'b1;
      end
      ST_BURST: begin
        cmd.load_burst = status.slot_free;
        cmd.shift      = status.slot_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[design/mwfs_dp.sv]
// ----------------------------------------------------------------------------
// mwfs_dp - window datapath
// Header window shift line, magic compare, length decode, output register.
// ----------------------------------------------------------------------------
module mwfs_dp #(
  parameter int HEADER_BYTES   = mwfs_pkg::HEADER_BYTES_DEF,
  parameter int CAPACITY_BYTES = mwfs_pkg::CAPACITY_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [63:0]            magic_word,
  input  mwfs_pkg::mwfs_cmd_t    cmd,
  output mwfs_pkg::mwfs_status_t status,
  mwfs_rx_if.sink                rx,
  mwfs_frame_if.source           res
);
  import mwfs_pkg::*;

  localparam int FILL_W = $clog2(HEADER_BYTES + 1);
  localparam int IDX_W  = $clog2(HEADER_BYTES);
  localparam int LEFT_W = $clog2(CAPACITY_BYTES);

  logic [7:0]        win [HEADER_BYTES];
  logic [FILL_W-1:0] fill;
  logic              in_frame;
  logic [LEFT_W-1:0] bytes_left;
  logic [DROP_W-1:0] drop_cnt;

  logic              out_valid;
  logic [1:0]        out_kind;
  logic [7:0]        out_byte;
  logic              out_first;
  logic              out_last;

  logic              accept;
  logic              slot_free;
  logic [IDX_W-1:0]  wr_idx;
  logic [31:0]       pkt_len;
  logic              match0;

  assign rx.ready  = cmd.in_ready;
  assign accept    = rx.valid && cmd.in_ready;
  assign slot_free = !out_valid || res.ready;
  assign wr_idx    = (fill >= FILL_W'(HEADER_BYTES)) ? '0 : fill[IDX_W-1:0];

  // little-endian packet length at its fixed header offset
  assign pkt_len = {win[LEN_OFFSET+3], win[LEN_OFFSET+2], win[LEN_OFFSET+1], win[LEN_OFFSET]};

  always_comb begin
    match0 = 1'b1;
    for (int k = 0; k < MAGIC_LEN; k++) begin
      if (win[k] != magic_word[8*k +: 8]) begin
        match0 = 1'b0;
      end
    end
  end

  always_comb begin
    status              = '0;
    status.rx_valid     = rx.valid;
    status.in_frame     = in_frame;
    status.fill_to_full = fill == FILL_W'(HEADER_BYTES - 1);
    status.fill_full    = fill == FILL_W'(HEADER_BYTES);
    status.fill_low     = fill <= FILL_W'(MAGIC_LEN);
    status.fill_one     = fill == FILL_W'(1);
    status.match0       = match0;
    status.len_under    = pkt_len < 32'(HEADER_BYTES);
    status.len_over     = pkt_len > 32'(CAPACITY_BYTES);
    status.slot_free    = slot_free;
    status.drop_done    = drop_cnt == DROP_W'(1);
  end

  // window line: append at the fill point, or advance by one byte
  always_ff @(posedge clk) begin
    if (accept && !in_frame) begin
      win[wr_idx] <= rx.rx_byte;
    end else if (cmd.shift) begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      in_frame   <= 1'b0;
      bytes_left <= '0;
      drop_cnt   <= '0;
    end else begin
      if (accept && !in_frame) begin
        fill <= FILL_W'(wr_idx) + FILL_W'(1);
      end else if (cmd.shift) begin
        fill <= fill - FILL_W'(1);
      end

      if (cmd.drop_load) begin
        drop_cnt <= DROP_W'(MAGIC_LEN - 1);
      end else if (cmd.drop_dec) begin
        drop_cnt <= drop_cnt - DROP_W'(1);
      end

      if (cmd.set_frame) begin
        bytes_left <= LEFT_W'(pkt_len - 32'(HEADER_BYTES));
      end else if (accept && in_frame) begin
        bytes_left <= bytes_left - LEFT_W'(1);
        in_frame   <= bytes_left != LEFT_W'(1);
      end else if (cmd.load_burst && fill == FILL_W'(1)) begin
        in_frame <= bytes_left != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_event || cmd.load_burst || (accept && in_frame)) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_event) begin
      out_kind  <= cmd.event_kind;
      out_byte  <= '0;
      out_first <= 1'b0;
      out_last  <= 1'b0;
    end else if (cmd.load_burst) begin
      out_kind  <= EV_FRAME;
      out_byte  <= win[0];
      out_first <= fill == FILL_W'(HEADER_BYTES);
      out_last  <= (fill == FILL_W'(1)) && (bytes_left == '0);
    end else if (accept && in_frame) begin
      out_kind  <= EV_FRAME;
      out_byte  <= rx.rx_byte;
      out_first <= 1'b0;
      out_last  <= bytes_left == LEFT_W'(1);
    end
  end

  assign res.valid       = out_valid;
  assign res.event_kind  = out_kind;
  assign res.frame_byte  = out_byte;
  assign res.frame_first = out_first;
  assign res.frame_last  = out_last;

  a_frame_has_body: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> bytes_left != '0)
    else $error("frame body open with no bytes left");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HEADER_BYTES))
    else $error("window fill beyond header size");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> fill != '0)
    else $error("window advanced while empty");

  a_event_zero_byte: assert property (@(posedge clk) disable iff (rst)
    cmd.load_event |=> out_valid && out_byte == '0 && !out_first && !out_last)
    else $error("event result carries frame data");

endmodule

[dv/mwfs_frame_monitor.sv]
// ----------------------------------------------------------------------------
// mwfs_frame_monitor - frame result predictor and comparator
// Watches the received bytes and the configuration port, works out the frame
// bytes and events each transfer should cause, and compares them with the
// frame results as they leave the block.
// ----------------------------------------------------------------------------
module mwfs_frame_monitor #(
  parameter int HEADER_BYTES   = mwfs_pkg::HEADER_BYTES_DEF,
  parameter int CAPACITY_BYTES = mwfs_pkg::CAPACITY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  mwfs_rx_if                            rx_stream,
  mwfs_frame_if                         frame_stream,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [mwfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [mwfs_pkg::PDATA_W-1:0]  pwdata,
  output int                            mismatches,
  output int                            results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import mwfs_pkg::*;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] frame_byte;
    logic       frame_first;
    logic       frame_last;
  } frame_result_t;

  logic [63:0]   sync_word;
  logic [7:0]    win [HEADER_BYTES];
  int            win_fill;
  logic          in_body;
  logic [14:0]   body_left;
  frame_result_t frames_due [$];

  function automatic void due_push(input logic [1:0] kind, input logic [7:0] data,
                                   input logic first, input logic last);
    frames_due.push_back('{kind, data, first, last});
  endfunction

  function automatic void drop_front(input int count);
    if (count >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i < win_fill - count; i++) win[i] = win[i + count];
      win_fill -= count;
    end
  endfunction

  // One received byte: pass it through inside a frame, else window and scan.
  function automatic void absorb_byte(input logic [7:0] b);
    int          hit;
    logic [31:0] len;
    if (in_body) begin
      if (body_left != 0) body_left--;
      if (body_left == 0) in_body = 1'b0;
      due_push(EV_FRAME, b, 1'b0, body_left == 0);
      return;
    end
    if (win_fill >= HEADER_BYTES) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    if (win_fill < HEADER_BYTES) return;

    hit = -1;
    for (int pos = 0; pos + MAGIC_LEN <= win_fill && hit < 0; pos++) begin
      hit = pos;
      for (int k = 0; k < MAGIC_LEN; k++)
        if (win[pos + k] != sync_word[8*k +: 8]) hit = -1;
    end
    // no sync word anywhere: keep the tail that could start one
    if (hit < 0) begin
      drop_front(win_fill - (MAGIC_LEN - 1));
      return;
    end
    if (hit > 0) begin
      drop_front(hit);
      return;
    end

    len = {win[LEN_OFFSET + 3], win[LEN_OFFSET + 2], win[LEN_OFFSET + 1], win[LEN_OFFSET]};
    if (len < HEADER_BYTES) begin
      drop_front(1);
      due_push(EV_UNDERSIZED, 8'h00, 1'b0, 1'b0);
    end else if (len > CAPACITY_BYTES) begin
      drop_front(MAGIC_LEN);
      due_push(EV_OVERSIZED, 8'h00, 1'b0, 1'b0);
    end else begin
      for (int k = 0; k < HEADER_BYTES; k++)
        due_push(EV_FRAME, win[k], k == 0, len == HEADER_BYTES && k == HEADER_BYTES - 1);
      win_fill  = 0;
      body_left = 15'(len - HEADER_BYTES);
      in_body   = body_left != 0;
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      sync_word  = MAGIC_RESET;
      win_fill   = 0;
      in_body    = 1'b0;
      body_left  = '0;
      mismatches = 0;
      frames_due.delete();
    end else begin
      if (frame_stream.valid && frame_stream.ready) begin
        got = '{frame_stream.event_kind, frame_stream.frame_byte,
                frame_stream.frame_first, frame_stream.frame_last};
        if (frames_due.size() == 0) begin
          $error("unexpected frame result: event_kind %0d frame_byte %02h",
                 got.event_kind, got.frame_byte);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (got.event_kind != want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, got.event_kind);
            mismatches++;
          end
          if (got.frame_byte != want.frame_byte) begin
            $error("frame_byte: expected %02h, got %02h", want.frame_byte, got.frame_byte);
            mismatches++;
          end
          if (got.frame_first != want.frame_first) begin
            $error("frame_first: expected %0b, got %0b", want.frame_first, got.frame_first);
            mismatches++;
          end
          if (got.frame_last != want.frame_last) begin
            $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
            mismatches++;
          end
        end
      end
      if (rx_stream.valid && rx_stream.ready) absorb_byte(rx_stream.rx_byte);
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:3] == REG_MAGIC)
        sync_word = pwdata;
    end
    results_due = frames_due.size();
  end

endmodule

[dv/tb_magic_word_frame_sync_top.sv]
// ----------------------------------------------------------------------------
// tb_magic_word_frame_sync_top - frame synchroniser testbench
// Feeds byte streams of well-formed, truncated, undersized and oversized
// frames mixed with noise, under several sync words and flow-control
// patterns, and leaves all checking to the frame monitor beside the block.
// ----------------------------------------------------------------------------
module tb_magic_word_frame_sync_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mwfs_pkg::*;

  localparam int HEADER_BYTES   = HEADER_BYTES_DEF;
  localparam int CAPACITY_BYTES = CAPACITY_BYTES_DEF;

  // Register map: one 64-bit register per 8-byte slot
  localparam logic [PADDR_W-1:0] ADDR_MAGIC  = {REG_MAGIC, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = ADDR_MAGIC + 4'd8;

  // Quiet time after the last result before touching the register, long
  // enough for a full window scan, the length decode and the magic drop.
  localparam int SETTLE_CYCLES = 2 * HEADER_BYTES;
  localparam int HOLD_CYCLES   = 400;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int          mismatches;
  int          results_due;
  int          feed_gap_pct;
  int          drain_stall_pct;
  logic        hold_go;
  logic        drain_hold;
  logic [63:0] link_magic;

  mwfs_rx_if    rx_stream_if ();
  mwfs_frame_if frame_stream_if ();

  magic_word_frame_sync_top #(
    .HEADER_BYTES   (HEADER_BYTES),
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_stream    (rx_stream_if),
    .frame_stream (frame_stream_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mwfs_frame_monitor #(
    .HEADER_BYTES   (HEADER_BYTES),
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) frame_monitor (
    .clk          (clk),
    .rst          (rst),
    .rx_stream    (rx_stream_if),
    .frame_stream (frame_stream_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .results_due  (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run: the slowest correct run stays well inside this.
  initial begin
    #5_000_000;
    $display("tb_magic_word_frame_sync_top: FAIL");
    $finish;
  end

  // Long receiver hold-off, counted here so the sender keeps offering bytes
  // while the block backs up and stalls its input.
  initial begin
    drain_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    drain_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    drain_hold = 1'b0;
  end

  // Result receiver: decide ready once per cycle at the falling edge.
  initial begin
    frame_stream_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      frame_stream_if.ready <= !drain_hold && ($urandom_range(99) >= drain_stall_pct);
    end
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < feed_gap_pct) begin
      rx_stream_if.valid <= 1'b0;
      @(negedge clk);
    end
    rx_stream_if.valid   <= 1'b1;
    rx_stream_if.rx_byte <= b;
    do @(posedge clk); while (!rx_stream_if.ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_byte(8'($urandom));
  endtask

  // First count bytes of a header: sync word, random filler, and the
  // little-endian packet length at its fixed offset.
  task automatic send_header(input logic [31:0] len, input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      if (i < MAGIC_LEN)
        b = link_magic[8*i +: 8];
      else if (i >= LEN_OFFSET && i < LEN_OFFSET + 4)
        b = len[8*(i - LEN_OFFSET) +: 8];
      else
        b = 8'($urandom);
      send_byte(b);
    end
  endtask

  // Drop valid and wait for the block to go quiet: every predicted result
  // out, then time for a scan or a magic drop that causes no result.
  task automatic settle();
    rx_stream_if.valid <= 1'b0;
    wait (results_due == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // rising edge where psel, penable, pwrite and pready are all high.
  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    if (addr == ADDR_MAGIC) link_magic = data;
  endtask

  initial begin
    // Every input known from time zero
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    rx_stream_if.valid   = 1'b0;
    rx_stream_if.rx_byte = '0;
    hold_go              = 1'b0;
    link_magic           = MAGIC_RESET;
    feed_gap_pct         = 31;
    drain_stall_pct      = 57;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset sync word.
    // Two-byte body at the extremes
    send_header(HEADER_BYTES + 2, HEADER_BYTES);
    send_byte(8'h00);
    send_byte(8'hFF);
    // Length one below the header: undersized event, one byte dropped
    send_header(HEADER_BYTES - 1, HEADER_BYTES);
    // Length all ones: oversized event, magic word dropped
    send_header(32'hFFFF_FFFF, HEADER_BYTES);

    // All-ones sync word; receiver now idles less than the sender.
    // A full window of noise, then resync on a frame of exactly one header
    settle();
    cfg_write(ADDR_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
    feed_gap_pct    = 57;
    drain_stall_pct = 31;
    send_random(HEADER_BYTES);
    send_header(HEADER_BYTES, HEADER_BYTES);

    // All-zero sync word, a write to the empty slot that must change
    // nothing, and no idling at all
    settle();
    cfg_write(ADDR_UNUSED, {$urandom, $urandom});
    cfg_write(ADDR_MAGIC, 64'h0);
    feed_gap_pct    = 0;
    drain_stall_pct = 0;
    // Largest frame length the block accepts, with the receiver held off
    // while the header streams in; the body is left open at the end of the
    // run
    hold_go = 1'b1;
    send_header(CAPACITY_BYTES, HEADER_BYTES);
    send_random(20);

    settle();
    if (mismatches == 0 && results_due == 0) begin
      $display("tb_magic_word_frame_sync_top: PASS");
    end else begin
      $display("tb_magic_word_frame_sync_top: FAIL");
    end
    $finish;
  end

endmodule

[magic_word_frame_sync_top.f]
design/mwfs_pkg.sv
design/mwfs_rx_if.sv
design/mwfs_frame_if.sv
design/mwfs_regs.sv
design/mwfs_ctrl.sv
design/mwfs_dp.sv
design/magic_word_frame_sync_top.sv
dv/mwfs_frame_monitor.sv
dv/tb_magic_word_frame_sync_top.sv
